@@ src/aarp_pkg.sv @@
// Shared constants, widths and register codes for the axis-angle rotate and project block.
package aarp_pkg;

  // Field and register widths
  localparam int CoordWidth = 16;
  localparam int AxisW      = 16;
  localparam int CfgIdxW    = 3;
  localparam int ScreenOutW = 10;

  // Screen and window geometry
  localparam int ScreenSize = 800;
  localparam int ScreenW    = 13;
  localparam int WinHalf    = 5;
  localparam int WinSize    = 10;
  localparam int FracBits   = 22;
  localparam int OneQ14     = 16384;
  localparam int TrigFrac   = 14;
  localparam int DotShift   = 8;
  localparam int AxwShift   = 6;

  // Datapath widths derived from the field widths
  localparam int ProdW   = CoordWidth + AxisW;
  localparam int CrossW  = ProdW + 1;
  localparam int DotSumW = ProdW + 2;
  localparam int DotW    = DotSumW - DotShift;
  localparam int OmcW    = AxisW + 1;
  localparam int DwW     = DotW + OmcW;
  localparam int WW      = DwW - TrigFrac;
  localparam int AxwW    = WW + AxisW;
  localparam int CsW     = CrossW + AxisW;
  localparam int TermW   = CsW - TrigFrac;
  localparam int RotW    = AxwW - AxwShift + 2;

  // Window offset and span at the rotated-point scale
  localparam longint WinLim  = longint'(WinHalf) << FracBits;
  localparam longint WinSpan = longint'(WinSize) << FracBits;
  localparam int     DxW     = FracBits + 4;
  localparam int     NumW    = DxW + ScreenW + 1;

  // Divide-by-ten through a reciprocal, exact for quotient inputs below 81920
  localparam int TquoW      = 17;
  localparam int RecipTen   = 52429;
  localparam int RecipShift = 19;
  localparam int MulTenW    = TquoW + 16;
  localparam int QuoW       = MulTenW - RecipShift;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgAxisX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAxisY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAxisZ = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCos   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSin   = 3'd4;

endpackage

@@ src/axis_angle_rotate_project.sv @@
// Top level: Rodrigues rotation of a point about a unit axis and orthographic screen mapping.
// Throughput: one point per cycle unless the output stalls.
// Seven register stages, at most one multiply layer per stage.
// A stalled output holds its stage; upstream stages keep filling into bubbles.
// Reset: asynchronous, active low; clears all valid bits and loads the
// configuration registers with axis (1,0,0), cos 1.0, sin 0.
module axis_angle_rotate_project
  import aarp_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [AxisW-1:0]             cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [CoordWidth-1:0] point_x_i,
  input  logic signed [CoordWidth-1:0] point_y_i,
  input  logic signed [CoordWidth-1:0] point_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ScreenOutW-1:0]        screen_x_o,
  output logic [ScreenOutW-1:0]        screen_y_o,
  output logic                         visible_o
);

  localparam int NStage = 7;
  localparam logic signed [RotW-1:0] LimS  = RotW'(WinLim);
  localparam logic [NumW-1:0]        SpanM = NumW'(WinSpan - 1);

  // Configuration registers
  logic signed [AxisW-1:0] ax_q, ay_q, az_q, cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q  <= AxisW'(OneQ14);
      ay_q  <= '0;
      az_q  <= '0;
      cos_q <= AxisW'(OneQ14);
      sin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAxisX: ax_q  <= cfg_data_i;
        CfgAxisY: ay_q  <= cfg_data_i;
        CfgAxisZ: az_q  <= cfg_data_i;
        CfgCos:   cos_q <= cfg_data_i;
        CfgSin:   sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage load enables; a stage loads when empty or draining
  logic [NStage:1]   v_q;
  logic [NStage+1:1] en;

  always_comb begin
    en[NStage+1] = !out_stall_i;
    for (int k = NStage; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: axis-by-point and cosine products
  logic signed [ProdW-1:0] ayvz_q, azvy_q, azvx_q, axvz_q, axvx_q, ayvy_q, azvz_q;
  logic signed [ProdW-1:0] vxc1_q, vyc1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ayvz_q <= ay_q * point_z_i;
      azvy_q <= az_q * point_y_i;
      azvx_q <= az_q * point_x_i;
      axvz_q <= ax_q * point_z_i;
      axvx_q <= ax_q * point_x_i;
      ayvy_q <= ay_q * point_y_i;
      azvz_q <= az_q * point_z_i;
      vxc1_q <= point_x_i * cos_q;
      vyc1_q <= point_y_i * cos_q;
    end
  end

  // Stage 2: cross product and scaled dot product
  logic signed [CrossW-1:0]  crx_d, cry_d, crx_q, cry_q;
  logic signed [DotSumW-1:0] dsum;
  logic signed [DotW-1:0]    dot_q;
  logic signed [ProdW-1:0]   vxc2_q, vyc2_q;

  always_comb begin
    crx_d = CrossW'(ayvz_q) - CrossW'(azvy_q);
    cry_d = CrossW'(azvx_q) - CrossW'(axvz_q);
    dsum  = DotSumW'(axvx_q) + DotSumW'(ayvy_q) + DotSumW'(azvz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      crx_q  <= crx_d;
      cry_q  <= cry_d;
      dot_q  <= dsum[DotSumW-1:DotShift];
      vxc2_q <= vxc1_q;
      vyc2_q <= vyc1_q;
    end
  end

  // Stage 3: sine terms and dot times one minus cosine
  logic signed [OmcW-1:0] omc;
  logic signed [CsW-1:0]  csx_q, csy_q;
  logic signed [DwW-1:0]  dw_q;
  logic signed [ProdW-1:0] vxc3_q, vyc3_q;

  assign omc = OmcW'(OneQ14) - OmcW'(cos_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      csx_q  <= crx_q * sin_q;
      csy_q  <= cry_q * sin_q;
      dw_q   <= dot_q * omc;
      vxc3_q <= vxc2_q;
      vyc3_q <= vyc2_q;
    end
  end

  // Stage 4: axis times the parallel weight, floor the sine terms
  logic signed [WW-1:0]    w;
  logic signed [AxwW-1:0]  axw_q, ayw_q;
  logic signed [TermW-1:0] tx_q, ty_q;
  logic signed [ProdW-1:0] vxc4_q, vyc4_q;

  assign w = dw_q[DwW-1:TrigFrac];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      axw_q  <= ax_q * w;
      ayw_q  <= ay_q * w;
      tx_q   <= csx_q[CsW-1:TrigFrac];
      ty_q   <= csy_q[CsW-1:TrigFrac];
      vxc4_q <= vxc3_q;
      vyc4_q <= vyc3_q;
    end
  end

  // Stage 5: add the three Rodrigues terms
  logic signed [AxwW-AxwShift-1:0] pax, pay;
  logic signed [RotW-1:0]          rx_q, ry_q;

  always_comb begin
    pax = axw_q[AxwW-1:AxwShift];
    pay = ayw_q[AxwW-1:AxwShift];
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      rx_q <= RotW'(vxc4_q) + RotW'(tx_q) + RotW'(pax);
      ry_q <= RotW'(vyc4_q) + RotW'(ty_q) + RotW'(pay);
    end
  end

  // Stage 6: window test, scale to screen and drop the fractional bits
  logic                   inwin;
  logic signed [RotW-1:0] dx, dy;
  logic [NumW-1:0]        nx, ny;
  logic [TquoW-1:0]       qx6_q, qy6_q;
  logic                   vis6_q;

  always_comb begin
    inwin = (rx_q >= -LimS) && (rx_q <= LimS) && (ry_q >= -LimS) && (ry_q <= LimS);
    dx    = rx_q + LimS;
    dy    = ry_q + LimS;
    nx    = NumW'(dx[DxW-1:0]) * NumW'(ScreenSize);
    ny    = NumW'(dy[DxW-1:0]) * NumW'(ScreenSize) + SpanM;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      qx6_q  <= nx[FracBits +: TquoW];
      qy6_q  <= ny[FracBits +: TquoW];
      vis6_q <= inwin;
    end
  end

  // Stage 7: divide by the window size and flip the screen row
  logic [MulTenW-1:0] mx, my;
  logic [QuoW-1:0]    qx, qy, syf;
  logic [ScreenOutW-1:0] sx_q, sy_q;
  logic               vis_q;

  always_comb begin
    mx  = MulTenW'(qx6_q) * MulTenW'(RecipTen);
    my  = MulTenW'(qy6_q) * MulTenW'(RecipTen);
    qx  = mx[RecipShift +: QuoW];
    qy  = my[RecipShift +: QuoW];
    syf = QuoW'(ScreenSize) - qy;
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      sx_q  <= vis6_q ? qx[ScreenOutW-1:0] : '0;
      sy_q  <= vis6_q ? syf[ScreenOutW-1:0] : '0;
      vis_q <= vis6_q;
    end
  end

  assign out_valid_o = v_q[NStage];
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign visible_o   = vis_q;

endmodule

@@ dv/aarp_checker.sv @@
// Checker for the rotate-and-project block: predicts each screen beat and compares it.
`timescale 1ns / 100ps

module aarp_checker
  import aarp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [AxisW-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CoordWidth-1:0] point_x_i,
  input  logic [CoordWidth-1:0] point_y_i,
  input  logic [CoordWidth-1:0] point_z_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [ScreenOutW-1:0] screen_x_i,
  input  logic [ScreenOutW-1:0] screen_y_i,
  input  logic                  visible_i,
  output int                    err_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [ScreenOutW-1:0] sx;
    logic [ScreenOutW-1:0] sy;
    logic                  vis;
  } pixel_t;

  // Shadow copy of the configuration registers
  logic signed [AxisW-1:0] ax_r, ay_r, az_r, cos_r, sin_r;

  // Screen beats still owed by the block, oldest first
  pixel_t pixel_q[$];

  // Rotate one point about the axis and map it onto the screen
  function automatic pixel_t project_point(logic signed [CoordWidth-1:0] px,
                                           logic signed [CoordWidth-1:0] py,
                                           logic signed [CoordWidth-1:0] pz);
    longint vx, vy, vz, kx, ky, kz, cs, sn;
    longint omc, crs_x, crs_y, dotv, wt, rx, ry, dx, dy, qx, qy, row;
    pixel_t res;
    vx = px;
    vy = py;
    vz = pz;
    kx = ax_r;
    ky = ay_r;
    kz = az_r;
    cs = cos_r;
    sn = sin_r;
    omc   = OneQ14 - cs;
    crs_x = ky * vz - kz * vy;
    crs_y = kz * vx - kx * vz;
    dotv  = (kx * vx + ky * vy + kz * vz) >>> DotShift;
    wt    = (dotv * omc) >>> TrigFrac;
    rx    = vx * cs + ((crs_x * sn) >>> TrigFrac) + ((kx * wt) >>> AxwShift);
    ry    = vy * cs + ((crs_y * sn) >>> TrigFrac) + ((ky * wt) >>> AxwShift);
    res   = '0;
    // Window bounds are inclusive; anything outside maps to an invisible zero pixel
    if (rx >= -WinLim && rx <= WinLim && ry >= -WinLim && ry <= WinLim) begin
      dx      = rx + WinLim;
      dy      = ry + WinLim;
      qx      = (dx * ScreenSize) / WinSpan;
      qy      = (dy * ScreenSize + WinSpan - 1) / WinSpan;
      row     = ScreenSize - qy;
      res.sx  = qx[ScreenOutW-1:0];
      res.sy  = row[ScreenOutW-1:0];
      res.vis = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      ax_r        = AxisW'(OneQ14);
      ay_r        = '0;
      az_r        = '0;
      cos_r       = AxisW'(OneQ14);
      sin_r       = '0;
      pixel_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      // Predict an accepted point with the registers in force before this edge
      if (in_valid_i && !in_stall_i) begin
        pixel_q.push_back(project_point(point_x_i, point_y_i, point_z_i));
      end

      // Compare an accepted screen beat with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $error("screen beat with no point pending: x=%0d y=%0d visible=%0d",
                 screen_x_i, screen_y_i, visible_i);
          err_count_o++;
        end else begin
          want = pixel_q.pop_front();
          if (screen_x_i !== want.sx) begin
            $error("screen_x: expected %0d, got %0d", want.sx, screen_x_i);
            err_count_o++;
          end
          if (screen_y_i !== want.sy) begin
            $error("screen_y: expected %0d, got %0d", want.sy, screen_y_i);
            err_count_o++;
          end
          if (visible_i !== want.vis) begin
            $error("visible: expected %0d, got %0d", want.vis, visible_i);
            err_count_o++;
          end
        end
      end

      // Track register writes; indexes beyond the list change nothing
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgAxisX: ax_r = cfg_data_i;
          CfgAxisY: ay_r = cfg_data_i;
          CfgAxisZ: az_r = cfg_data_i;
          CfgCos:   cos_r = cfg_data_i;
          CfgSin:   sin_r = cfg_data_i;
          default: ;
        endcase
      end

      pending_o = pixel_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top: drives points and register writes into the rotate-and-project block.
`timescale 1ns / 100ps

module tb
  import aarp_pkg::*;
();

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 150;
  localparam int RandPhases  = 12;
  localparam int PhaseItems  = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CfgIdxW-1:0]    cfg_idx;
  logic [AxisW-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [CoordWidth-1:0] point_x, point_y, point_z;
  logic                  out_valid;
  logic                  out_stall;
  logic [ScreenOutW-1:0] screen_x, screen_y;
  logic                  visible;

  int err_count;
  int pending;
  int cycle_cnt;
  int hold_gen;
  logic calm;

  axis_angle_rotate_project u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .point_z_i   (point_z),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .screen_x_o  (screen_x),
    .screen_y_o  (screen_y),
    .visible_o   (visible)
  );

  aarp_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .point_z_i   (point_z),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .screen_x_i  (screen_x),
    .screen_y_i  (screen_y),
    .visible_i   (visible),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: done, errors");
    $finish;
  end

  // Receiver: random stalls, a calm stretch, and long hold-offs on request
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_gen != seen) begin
        seen      = hold_gen;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 18);
      end
    end
  end

  // Offer one point beat, with a random gap first, and hold it until accepted
  task automatic send_point(input logic [CoordWidth-1:0] px,
                            input logic [CoordWidth-1:0] py,
                            input logic [CoordWidth-1:0] pz);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= px;
    point_y  <= py;
    point_z  <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every owed beat, then let the pipeline empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Load all registers, plus one write to an index past the list
  task automatic set_regs(input logic [AxisW-1:0] kx, input logic [AxisW-1:0] ky,
                          input logic [AxisW-1:0] kz, input logic [AxisW-1:0] cs,
                          input logic [AxisW-1:0] sn);
    logic [CfgIdxW-1:0] idx_seq [6];
    logic [AxisW-1:0]   val_seq [6];
    idx_seq = '{CfgAxisX, CfgAxisY, CfgAxisZ, CfgCos, CfgSin,
                CfgSin + CfgIdxW'($urandom_range(3, 1))};
    val_seq = '{kx, ky, kz, cs, sn, AxisW'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_seq[i];
      cfg_data <= val_seq[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly near the window, some on its edges, some anywhere
  function automatic logic [CoordWidth-1:0] pick_coord();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 65) begin
      v = int'($urandom_range(3200)) - 1600;
    end else if (r < 80) begin
      v = ($urandom_range(1) ? 1280 : -1280) + int'($urandom_range(6)) - 3;
    end else begin
      v = $urandom;
    end
    return v[CoordWidth-1:0];
  endfunction

  // Mostly in range, sometimes the extremes, sometimes any 16-bit value
  function automatic logic [AxisW-1:0] pick_reg();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 80) begin
      v = int'($urandom_range(32768)) - 16384;
    end else if (r < 90) begin
      case ($urandom_range(2))
        0: v = OneQ14;
        1: v = -OneQ14;
        default: v = 0;
      endcase
    end else begin
      v = $urandom;
    end
    return v[AxisW-1:0];
  endfunction

  initial begin
    calm     = 1'b0;
    hold_gen = 0;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    point_x  <= '0;
    point_y  <= '0;
    point_z  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity rotation after reset: corners, just outside, field extremes
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(16'sd1280, 16'sd1280, 16'sd0);
    send_point(-16'sd1280, -16'sd1280, 16'sd0);
    send_point(-16'sd1280, 16'sd1280, 16'sd32767);
    send_point(16'sd1281, 16'sd0, 16'sd0);
    send_point(16'sd0, -16'sd1281, 16'sd0);
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'sd5, -16'sd7, 16'sd100);
    wait_drained();

    // Quarter turn about z
    set_regs(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
    send_point(16'sd1280, 16'sd0, 16'sd0);
    send_point(16'sd0, -16'sd1280, 16'sd0);
    send_point(16'sd700, -16'sd300, 16'sd9);
    wait_drained();

    // Negative extremes on every register; axis far from unit length
    set_regs(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_point(16'sd300, -16'sd200, 16'sd100);
    send_point(16'sd1280, 16'sd1280, 16'sd1280);
    send_point(16'h8000, 16'sd32767, 16'sd0);
    wait_drained();

    // Register values outside the nominal range
    set_regs(16'h8000, 16'h7FFF, 16'h8001, 16'h7FFF, 16'h8000);
    send_point(16'sd10, 16'sd20, -16'sd30);
    send_point(16'sd1, -16'sd1, 16'sd1);
    send_point(16'hFFFF, 16'sd0, 16'sd0);
    wait_drained();

    // Random phases: fresh registers, then a burst of random points
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        set_regs(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
      end else begin
        set_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
      end
      calm = (p == 5);
      for (int i = 0; i < PhaseItems; i++) begin
        // Hold the receiver off long enough to back up the pipeline
        if ((p == 3 || p == 8) && i == 30) hold_gen++;
        // Pause the sender until every owed beat is out
        if (p == 7 && i == 60) wait_drained();
        send_point(pick_coord(), pick_coord(), pick_coord());
      end
      wait_drained();
    end
    calm = 1'b0;

    if (err_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
